// ===== rtl/core/sct_pkg.sv =====
package sct_pkg;

    localparam int FRACTION_BITS = 13;
    localparam int GUARD_BITS    = 12;
    localparam int IB            = FRACTION_BITS + GUARD_BITS;
    localparam int MAX_TERMS_DEF = 10;

    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 18;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] TERM_COUNT_RST = CFG_W'(5);

    localparam int TERM_W     = 48;
    localparam int HALF_W     = TERM_W / 2;
    localparam int PROD_W     = HALF_W + ANGLE_W;
    localparam int ACC_W      = TERM_W + ANGLE_W + 1;
    localparam int DVD_W      = ACC_W - FRACTION_BITS;
    localparam int DIGIT_W    = 8;
    localparam int DIV_CHUNKS = (DVD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DVD_PAD    = DIV_CHUNKS * DIGIT_W;
    localparam int CHUNK_CW   = $clog2(DIV_CHUNKS);
    localparam int SUM_W      = TERM_W + 6;
    localparam int RM_W       = SUM_W - GUARD_BITS + 1;

    localparam logic [TERM_W-1:0] TERM_ONE   = TERM_W'(1) << IB;
    localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [OUT_W-1:0]  OUT_MAX_C  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]  OUT_MIN_C  = {1'b1, {(OUT_W-1){1'b0}}};

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE   = 3'd0;
    localparam t_pc PC_INIT   = 3'd1;
    localparam t_pc PC_MUL_LO = 3'd2;
    localparam t_pc PC_MUL_HI = 3'd3;
    localparam t_pc PC_DIV    = 3'd4;
    localparam t_pc PC_CLAMP  = 3'd5;
    localparam t_pc PC_SUM    = 3'd6;
    localparam t_pc PC_OUT    = 3'd7;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_INIT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV,
        OP_CLAMP,
        OP_SUM,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_NO_BEAT,
        JC_DIV_MORE,
        JC_TERM_MORE,
        JC_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic term_more;
        logic out_busy;
    } t_flags;

    function automatic t_ucode ucode_rom(input t_pc pc);
        t_ucode w;
        unique case (pc)
            PC_IDLE:   w = '{op: OP_WAIT,   cond: JC_NO_BEAT,   target: PC_IDLE};
            PC_INIT:   w = '{op: OP_INIT,   cond: JC_NONE,      target: PC_IDLE};
            PC_MUL_LO: w = '{op: OP_MUL_LO, cond: JC_NONE,      target: PC_IDLE};
            PC_MUL_HI: w = '{op: OP_MUL_HI, cond: JC_NONE,      target: PC_IDLE};
            PC_DIV:    w = '{op: OP_DIV,    cond: JC_DIV_MORE,  target: PC_DIV};
            PC_CLAMP:  w = '{op: OP_CLAMP,  cond: JC_NONE,      target: PC_IDLE};
            PC_SUM:    w = '{op: OP_SUM,    cond: JC_TERM_MORE, target: PC_MUL_LO};
            PC_OUT:    w = '{op: OP_OUT,    cond: JC_OUT_BUSY,  target: PC_OUT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/sct_seq.sv =====
module sct_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sct_pkg::t_flags i_flags,
    output sct_pkg::t_ucode o_uword
);
    import sct_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_ucode w_uword;
    logic   w_jump;

    assign w_uword = ucode_rom(r_pc);
    assign o_uword = w_uword;

    always_comb begin
        unique case (w_uword.cond)
            JC_NONE:      w_jump = 1'b0;
            JC_NO_BEAT:   w_jump = !i_flags.in_valid;
            JC_DIV_MORE:  w_jump = i_flags.div_more;
            JC_TERM_MORE: w_jump = i_flags.term_more;
            JC_OUT_BUSY:  w_jump = i_flags.out_busy;
            default:      w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uword.target : t_pc'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/sct_dpath.sv =====
module sct_dpath #(
    parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sct_pkg::t_ucode                    i_uword,
    input  logic                               i_in_valid,
    input  logic signed [sct_pkg::ANGLE_W-1:0] i_angle,
    input  logic [sct_pkg::CFG_W-1:0]          i_term_count,
    input  logic                               i_out_stall,
    output sct_pkg::t_flags                    o_flags,
    output logic                               o_out_valid,
    output logic signed [sct_pkg::OUT_W-1:0]   o_sine_value,
    output logic signed [sct_pkg::OUT_W-1:0]   o_cosine_value
);
    import sct_pkg::*;

    localparam int N_W = $clog2(2 * MAX_TERMS + 2);

    logic                     r_xneg;
    logic [ANGLE_W-1:0]       r_xmag;
    logic [N_W-1:0]           r_n;
    logic [N_W-1:0]           r_last;
    logic [TERM_W-1:0]        r_tmag;
    logic [ACC_W-1:0]         r_acc;
    logic [DVD_PAD-1:0]       r_dvd;
    logic [DVD_PAD-1:0]       r_quo;
    logic [N_W-1:0]           r_rem;
    logic [CHUNK_CW-1:0]      r_chunk;
    logic signed [SUM_W-1:0]  r_sin;
    logic signed [SUM_W-1:0]  r_cos;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_sine_out;
    logic [OUT_W-1:0]         r_cos_out;

    logic [CFG_W-1:0]         w_k;
    logic [N_W-1:0]           w_last;
    logic [HALF_W-1:0]        w_mul_a;
    logic [PROD_W-1:0]        w_prod;
    logic [ACC_W-1:0]         w_acc_hi;
    logic [N_W-1:0]           w_rem;
    logic [N_W:0]             w_trial;
    logic [DIGIT_W-1:0]       w_qbits;
    logic                     w_neg;
    logic signed [SUM_W-1:0]  w_ext;
    logic signed [SUM_W-1:0]  w_term;
    logic                     w_out_busy;

    function automatic logic [OUT_W-1:0] round_out(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        logic [RM_W-1:0]  rm;
        logic [OUT_W-1:0] res;
        mag = s[SUM_W-1] ? $unsigned(-s) : $unsigned(s);
        rm  = RM_W'((mag + (SUM_W'(1) << (GUARD_BITS - 1))) >> GUARD_BITS);
        if (s[SUM_W-1]) begin
            res = (rm > RM_W'(OUT_MIN_C)) ? OUT_MIN_C : OUT_W'(~rm + 1'b1);
        end else begin
            res = (rm > RM_W'(OUT_MAX_C)) ? OUT_MAX_C : OUT_W'(rm);
        end
        return res;
    endfunction

    // clamp k and form the last series index 2k+1
    assign w_k    = (i_term_count > CFG_W'(MAX_TERMS)) ? CFG_W'(MAX_TERMS) : i_term_count;
    assign w_last = N_W'({w_k, 1'b1});

    // one shared multiplier, low then high half of the term
    assign w_mul_a  = (i_uword.op == OP_MUL_HI) ? r_tmag[TERM_W-1:HALF_W]
                                                : r_tmag[HALF_W-1:0];
    assign w_prod   = w_mul_a * r_xmag;
    assign w_acc_hi = r_acc + (ACC_W'(w_prod) << HALF_W);

    // radix-256 restoring divide by the term index
    always_comb begin
        w_rem   = r_rem;
        w_trial = '0;
        w_qbits = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            w_trial = {w_rem, r_dvd[DVD_PAD-1-i]};
            if (w_trial >= {1'b0, r_n}) begin
                w_trial                = w_trial - {1'b0, r_n};
                w_qbits[DIGIT_W-1-i] = 1'b1;
            end
            w_rem = w_trial[N_W-1:0];
        end
    end

    assign w_neg  = (r_xneg & r_n[0]) ^ r_n[1];
    assign w_ext  = $signed(SUM_W'(r_tmag));
    assign w_term = w_neg ? (SUM_W'(0) - w_ext) : w_ext;

    assign w_out_busy = r_out_valid & i_out_stall;

    assign o_flags.in_valid  = i_in_valid;
    assign o_flags.div_more  = (r_chunk != CHUNK_CW'(DIV_CHUNKS - 1));
    assign o_flags.term_more = (r_n != r_last);
    assign o_flags.out_busy  = w_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_chunk     <= '0;
        end else begin
            if (i_uword.op == OP_OUT && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_uword.op)
                OP_INIT:   r_n     <= N_W'(1);
                OP_SUM:    r_n     <= r_n + 1'b1;
                OP_MUL_HI: r_chunk <= '0;
                OP_DIV:    r_chunk <= r_chunk + 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            OP_WAIT: begin
                if (i_in_valid) begin
                    r_xneg <= i_angle[ANGLE_W-1];
                    r_xmag <= i_angle[ANGLE_W-1] ? $unsigned(~i_angle + 1'b1)
                                                 : $unsigned(i_angle);
                    r_last <= w_last;
                end
            end
            OP_INIT: begin
                r_tmag <= TERM_ONE;
                r_sin  <= '0;
                r_cos  <= $signed(SUM_W'(TERM_ONE));
            end
            OP_MUL_LO: begin
                r_acc <= ACC_W'(w_prod) + (ACC_W'(r_n) << (FRACTION_BITS - 1));
            end
            OP_MUL_HI: begin
                r_dvd <= DVD_PAD'(w_acc_hi[ACC_W-1:FRACTION_BITS]);
                r_rem <= '0;
            end
            OP_DIV: begin
                r_dvd <= r_dvd << DIGIT_W;
                r_quo <= {r_quo[DVD_PAD-DIGIT_W-1:0], w_qbits};
                r_rem <= w_rem;
            end
            OP_CLAMP: begin
                r_tmag <= (r_quo > DVD_PAD'(TERM_LIMIT)) ? TERM_LIMIT : r_quo[TERM_W-1:0];
            end
            OP_SUM: begin
                if (r_n[0]) begin
                    r_sin <= r_sin + w_term;
                end else begin
                    r_cos <= r_cos + w_term;
                end
            end
            OP_OUT: begin
                if (!w_out_busy) begin
                    r_sine_out <= round_out(r_sin);
                    r_cos_out  <= round_out(r_cos);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_sine_value   = $signed(r_sine_out);
    assign o_cosine_value = $signed(r_cos_out);

endmodule

// ===== rtl/core/sin_cos_taylor_series_core.sv =====
// Taylor-series sine and cosine of a signed Q3.13 angle, returned as saturated
// signed Q5.13 partial sums over series indexes 0..2K+1, where K is the term
// count register (reset 5, values above MAX_TERMS act as MAX_TERMS). One angle
// is worked at a time by a small microprogram. Each of the 2K+1 series terms
// takes two passes through a shared 24x16 multiplier, seven passes of an
// 8-bit-per-cycle divide by the term index, a clamp and an accumulate.
// The next angle is taken while a finished result still waits on the output;
// a result stalled downstream holds the core only once the following result
// is ready.
module sin_cos_taylor_series_core #(
    parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sct_pkg::ANGLE_W-1:0] i_angle,
    input  logic                               i_cfg_wr_en,
    input  logic [sct_pkg::CFG_W-1:0]          i_cfg_wr_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [sct_pkg::OUT_W-1:0]   o_sine_value,
    output logic signed [sct_pkg::OUT_W-1:0]   o_cosine_value
);
    import sct_pkg::*;

    logic [CFG_W-1:0] r_term_count;
    t_ucode           w_uword;
    t_flags           w_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_term_count <= i_cfg_wr_data;
        end
    end

    assign o_stall = (w_uword.op != OP_WAIT);

    sct_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    sct_dpath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uword        (w_uword),
        .i_in_valid     (i_valid),
        .i_angle        (i_angle),
        .i_term_count   (r_term_count),
        .i_out_stall    (i_stall),
        .o_flags        (w_flags),
        .o_out_valid    (o_valid),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

endmodule

// ===== dv/tb.sv =====
module tb;
    import sct_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int LONG_HOLD    = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ANGLE_PI     = 25736;
    localparam int PHASE_ITEMS  = 80;

    typedef struct packed {
        logic [OUT_W-1:0] sine;
        logic [OUT_W-1:0] cosine;
    } t_sincos;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic signed [ANGLE_W-1:0] i_angle       = '0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]          i_cfg_wr_data = '0;
    logic                      i_stall       = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [OUT_W-1:0]   o_sine_value;
    logic signed [OUT_W-1:0]   o_cosine_value;

    logic [ANGLE_W-1:0] angle_q[$];
    t_sincos            sincos_due_q[$];
    logic [CFG_W-1:0]   term_count_sh = TERM_COUNT_RST;
    bit                 angle_taken;
    bit                 result_taken;
    bit                 no_gaps;
    bit                 hold_req;
    int                 send_wait;
    int                 recv_wait;
    int                 hold_left;
    int                 cycle_count;
    int                 errors;

    logic [ANGLE_W-1:0] corner_angles[13] = '{
        16'h0000, ANGLE_W'(ANGLE_PI), ANGLE_W'(-ANGLE_PI), 16'h0001, 16'hFFFF,
        16'h7FFF, 16'h8000, ANGLE_W'(12868), ANGLE_W'(-12868), 16'h2000,
        16'hE000, 16'h5555, 16'hAAAA
    };

    int unsigned phase_tc[16] = '{0, 10, 15, 1, 3, 7, 12, 2, 9, 5, 4, 6, 8, 11, 13, 14};

    sin_cos_taylor_series_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_angle        (i_angle),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [OUT_W-1:0] round_saturate(input longint sum);
        logic        neg;
        logic [63:0] mag;
        longint      v;
        neg = sum < 0;
        mag = neg ? 64'(-sum) : 64'(sum);
        mag = (mag + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        if (neg) begin
            v = (mag > 64'd131072) ? -longint'(131072) : -longint'(mag);
        end else begin
            v = (mag > 64'd131071) ? longint'(131071) : longint'(mag);
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic t_sincos taylor_sincos(input logic [ANGLE_W-1:0] raw,
                                              input logic [CFG_W-1:0] tc);
        t_sincos     r;
        logic        xneg;
        logic        neg;
        logic [63:0] xmag;
        logic [63:0] tmag;
        logic [63:0] dv;
        longint      s_sum;
        longint      c_sum;
        longint      sv;
        int          k;
        xneg  = raw[ANGLE_W-1];
        xmag  = xneg ? 64'h10000 - 64'(raw) : 64'(raw);
        k     = (int'(tc) > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(tc);
        tmag  = 64'd1 << IB;
        s_sum = 0;
        c_sum = longint'(tmag);
        for (int n = 1; n <= 2 * k + 1; n++) begin
            dv   = 64'(n) << FRACTION_BITS;
            tmag = (tmag * xmag + dv / 2) / dv;
            if (tmag > 64'(TERM_LIMIT)) begin
                tmag = 64'(TERM_LIMIT);
            end
            // odd powers carry the angle sign, every other term flips
            neg = (xneg && n[0]) != n[1];
            sv  = neg ? -longint'(tmag) : longint'(tmag);
            if (n[0]) begin
                s_sum += sv;
            end else begin
                c_sum += sv;
            end
        end
        r.sine   = round_saturate(s_sum);
        r.cosine = round_saturate(c_sum);
        return r;
    endfunction

    function automatic int draw_wait();
        return no_gaps ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [ANGLE_W-1:0] draw_angle();
        if ($urandom_range(0, 4) == 0) begin
            return ANGLE_W'($urandom);
        end
        return ANGLE_W'($urandom_range(0, 2 * ANGLE_PI) - ANGLE_PI);
    endfunction

    // sample at the rising edge so a beat driven at the same falling edge is seen
    task automatic wait_drained();
        do @(posedge i_clk);
        while (angle_q.size() != 0 || i_valid || sincos_due_q.size() != 0);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_angle
        logic               nv;
        logic [ANGLE_W-1:0] na;
        nv = i_valid;
        na = i_angle;
        if (angle_taken) begin
            angle_taken = 1'b0;
            nv          = 1'b0;
            send_wait   = draw_wait();
        end
        if (!nv && i_rst_n) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (angle_q.size() != 0) begin
                nv = 1'b1;
                na = angle_q.pop_front();
            end
        end
        i_valid <= nv;
        i_angle <= na;
    end

    always @(negedge i_clk) begin : drive_stall
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (result_taken) begin
            result_taken = 1'b0;
            recv_wait    = draw_wait();
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (recv_wait > 0) begin
            recv_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_sincos due;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end else if (!i_rst_n) begin
            term_count_sh = TERM_COUNT_RST;
        end else begin
            if (i_valid && !o_stall) begin
                sincos_due_q.push_back(taylor_sincos(i_angle, term_count_sh));
                angle_taken = 1'b1;
            end
            // result beat
            if (o_valid && !i_stall) begin
                result_taken = 1'b1;
                if (sincos_due_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result sine %0d cosine %0d", $time,
                             o_sine_value, o_cosine_value);
                end else begin
                    due = sincos_due_q.pop_front();
                    if (o_sine_value !== due.sine) begin
                        errors++;
                        $display("%0t: sine expected %0d got %0d", $time,
                                 $signed(due.sine), o_sine_value);
                    end
                    if (o_cosine_value !== due.cosine) begin
                        errors++;
                        $display("%0t: cosine expected %0d got %0d", $time,
                                 $signed(due.cosine), o_cosine_value);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                term_count_sh = i_cfg_wr_data;
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        foreach (corner_angles[i]) begin
            angle_q.push_back(corner_angles[i]);
        end
        for (int p = 0; p < 16; p++) begin
            wait_drained();
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= CFG_W'(phase_tc[p]);
            @(negedge i_clk) i_cfg_wr_en <= 1'b0;
            @(posedge i_clk);
            no_gaps = (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                angle_q.push_back(draw_angle());
            end
            // long output hold while angles keep coming
            if (p == 1) begin
                hold_req = 1'b1;
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && sincos_due_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
